[hdl/tbpq_pkg.sv]
// Shared types and constants for the trimming two-band packet queue.
`default_nettype none
package tbpq_pkg;

  // Default number of descriptors each band can hold.
  localparam int BAND_DEPTH_DEF = 1024;

  // Width of the configuration register and its value after reset.
  localparam int MAX_SIZE_W = 11;
  localparam logic [MAX_SIZE_W-1:0] MAX_SIZE_RST = 11'd1000;

  // Operation codes.
  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  // Enqueue status codes.
  localparam logic [2:0] ST_DATA    = 3'd0;
  localparam logic [2:0] ST_CTRL    = 3'd1;
  localparam logic [2:0] ST_TRIM    = 3'd2;
  localparam logic [2:0] ST_DROP    = 3'd3;
  localparam logic [2:0] ST_NOT_ENQ = 3'd4;

  // Input item.
  typedef struct packed {
    logic [1:0]  operation;
    logic        is_data;
    logic [5:0]  other_flags;
    logic [15:0] payload_size;
    logic [15:0] body_bytes;
    logic [15:0] packet_tag;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [2:0]  enq_status;
    logic        out_valid;
    logic        out_band;
    logic [15:0] out_tag;
    logic        out_is_data;
    logic        out_chopped;
    logic [5:0]  out_other_flags;
    logic [15:0] out_payload_size;
  } out_item_t;

  // Stored descriptor, 40 bits.
  typedef struct packed {
    logic [15:0] payload;
    logic [5:0]  flags;
    logic        chop;
    logic        is_data;
    logic [15:0] tag;
  } entry_t;

  // Per-band strobes from the decode logic.
  typedef struct packed {
    logic push;
    logic pop;
    logic rd;
  } band_ctl_t;

endpackage
`default_nettype wire

[hdl/tbpq_band.sv]
// One descriptor band: a circular buffer with head, tail, fill count and registered read.
`default_nettype none
module tbpq_band #(
  parameter int BAND_DEPTH = tbpq_pkg::BAND_DEPTH_DEF,
  parameter int AW = $clog2(BAND_DEPTH),
  parameter int CW = $clog2(BAND_DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tbpq_pkg::band_ctl_t ctl,
  input  wire tbpq_pkg::entry_t  wr_entry,
  output logic [CW-1:0]          count,
  output tbpq_pkg::entry_t       rd_entry
);

  tbpq_pkg::entry_t mem [BAND_DEPTH];
  tbpq_pkg::entry_t rd_r;
  logic [AW-1:0]    head_r, head_nxt;
  logic [AW-1:0]    tail_r, tail_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  // Pointer advance with wrap at the last slot.
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (ctl.push) begin
      tail_nxt  = (tail_r == AW'(BAND_DEPTH - 1)) ? '0 : tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
    end
    if (ctl.pop) begin
      head_nxt  = (head_r == AW'(BAND_DEPTH - 1)) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Storage write at the tail and registered read at the head.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail_r] <= wr_entry;
    end
    if (ctl.rd) begin
      rd_r <= mem[head_r];
    end
  end

  assign count    = count_r;
  assign rd_entry = rd_r;

endmodule
`default_nettype wire

[hdl/trimming_two_band_packet_queue.sv]
// Top level of the two-band strict-priority descriptor queue with payload trimming.
// Registered result: it appears in the cycle after its item is accepted.
// One item per cycle without out_stall; single write and read band ports set this.
// Reset: synchronous active-low rst_n empties both bands and sets max_size to 1000.
// Stored descriptors are not cleared; only entries that were written are ever served.
`default_nettype none
module trimming_two_band_packet_queue #(
  parameter int BAND_DEPTH = tbpq_pkg::BAND_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire tbpq_pkg::in_item_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output tbpq_pkg::out_item_t                      out_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [tbpq_pkg::MAX_SIZE_W-1:0]     cfg_data
);

  localparam int AW  = $clog2(BAND_DEPTH);
  localparam int CW  = $clog2(BAND_DEPTH + 1);
  localparam int LW  = (CW > tbpq_pkg::MAX_SIZE_W) ? CW : tbpq_pkg::MAX_SIZE_W;
  localparam int LW1 = LW + 1;

  logic [tbpq_pkg::MAX_SIZE_W-1:0] max_size_r;
  logic [CW-1:0]        ctl_count, dat_count;
  tbpq_pkg::entry_t     ctl_rd, dat_rd;
  tbpq_pkg::entry_t     wr_entry;
  tbpq_pkg::band_ctl_t  ctl_band, dat_band;
  logic                 accept;
  logic [LW-1:0]        max_ext, limit, cc_ext, dc_ext;
  logic                 is_enq, is_deq, is_read;
  logic                 trim, to_data, full_ctl, full_dat, ctl_nz, dat_nz;
  logic [15:0]          trim_pay;
  logic [2:0]           status_nxt;
  logic                 res_valid_r;
  logic [2:0]           status_r;
  logic                 found_r, found_nxt;
  logic                 band_r, band_nxt;
  tbpq_pkg::entry_t     served;

  // Configuration register, always writable.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r <= tbpq_pkg::MAX_SIZE_RST;
    end else if (cfg_valid) begin
      max_size_r <= cfg_data;
    end
  end

  // A new item is taken whenever the result register is free or being drained.
  assign in_stall = res_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // Effective limit saturates at the band depth.
  assign max_ext = LW'(max_size_r);
  assign limit   = (max_ext > LW'(BAND_DEPTH)) ? LW'(BAND_DEPTH) : max_ext;
  assign cc_ext  = LW'(ctl_count);
  assign dc_ext  = LW'(dat_count);

  // Item decode and enqueue decision.
  always_comb begin
    is_enq   = (in_data.operation == tbpq_pkg::OP_ENQ);
    is_deq   = (in_data.operation == tbpq_pkg::OP_DEQ);
    is_read  = is_deq || (in_data.operation == tbpq_pkg::OP_PEEK);
    trim     = in_data.is_data && ((LW1'(dc_ext) + 1'b1) >= LW1'(limit));
    to_data  = in_data.is_data && !trim;
    full_ctl = (cc_ext >= limit);
    full_dat = (dc_ext >= limit);
    ctl_nz   = (ctl_count != '0);
    dat_nz   = (dat_count != '0);
    trim_pay = (in_data.body_bytes > in_data.payload_size) ?
               (in_data.body_bytes - in_data.payload_size) : 16'd0;

    wr_entry.tag     = in_data.packet_tag;
    wr_entry.is_data = in_data.is_data;
    wr_entry.chop    = trim;
    wr_entry.flags   = trim ? 6'd0 : in_data.other_flags;
    wr_entry.payload = trim ? trim_pay : in_data.payload_size;

    status_nxt = tbpq_pkg::ST_NOT_ENQ;
    if (is_enq) begin
      if (to_data) begin
        status_nxt = full_dat ? tbpq_pkg::ST_DROP : tbpq_pkg::ST_DATA;
      end else if (trim) begin
        status_nxt = full_ctl ? tbpq_pkg::ST_DROP : tbpq_pkg::ST_TRIM;
      end else begin
        status_nxt = full_ctl ? tbpq_pkg::ST_DROP : tbpq_pkg::ST_CTRL;
      end
    end

    found_nxt = is_read && (ctl_nz || dat_nz);
    band_nxt  = !ctl_nz;

    ctl_band.push = accept && is_enq && !to_data && !full_ctl;
    ctl_band.pop  = accept && is_deq && ctl_nz;
    ctl_band.rd   = accept;
    dat_band.push = accept && is_enq && to_data && !full_dat;
    dat_band.pop  = accept && is_deq && !ctl_nz && dat_nz;
    dat_band.rd   = accept;
  end

  tbpq_band #(.BAND_DEPTH(BAND_DEPTH), .AW(AW), .CW(CW)) u_ctl_band (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl_band),
    .wr_entry (wr_entry),
    .count    (ctl_count),
    .rd_entry (ctl_rd)
  );

  tbpq_band #(.BAND_DEPTH(BAND_DEPTH), .AW(AW), .CW(CW)) u_dat_band (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (dat_band),
    .wr_entry (wr_entry),
    .count    (dat_count),
    .rd_entry (dat_rd)
  );

  // Result register: valid flag under reset, payload loaded on each transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (accept) begin
      res_valid_r <= 1'b1;
    end else if (!out_stall) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      found_r  <= found_nxt;
      band_r   <= band_nxt;
    end
  end

  // Served descriptor comes from the registered read of the chosen band.
  assign served = found_r ? (band_r ? dat_rd : ctl_rd) : '0;

  assign out_valid                 = res_valid_r;
  assign out_data.enq_status       = status_r;
  assign out_data.out_valid        = found_r;
  assign out_data.out_band         = found_r && band_r;
  assign out_data.out_tag          = served.tag;
  assign out_data.out_is_data      = served.is_data;
  assign out_data.out_chopped      = served.chop;
  assign out_data.out_other_flags  = served.flags;
  assign out_data.out_payload_size = served.payload;

endmodule
`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the trimming two-band packet queue.
module tb;

  localparam int QDEPTH = tbpq_pkg::BAND_DEPTH_DEF;
  // The spare opcode must behave as a no-op.
  localparam logic [1:0] OP_IDLE = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_PCT = 21;
  localparam int SHOWN_FAULTS = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  tbpq_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tbpq_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tbpq_pkg::MAX_SIZE_W-1:0] cfg_data = '0;

  // Shadow copy of both bands and the packet limit.
  tbpq_pkg::entry_t ctrl_band [QDEPTH];
  tbpq_pkg::entry_t data_band [QDEPTH];
  int unsigned ctrl_head = 0;
  int unsigned ctrl_cnt = 0;
  int unsigned data_head = 0;
  int unsigned data_cnt = 0;
  logic [tbpq_pkg::MAX_SIZE_W-1:0] band_limit = tbpq_pkg::MAX_SIZE_RST;

  tbpq_pkg::in_item_t queued_events[$];
  tbpq_pkg::out_item_t awaited_outcomes[$];

  int fault_count = 0;
  int n_events = 0;
  int n_results = 0;
  int n_trimmed = 0;
  int n_dropped = 0;
  int n_served = 0;
  int n_limits = 0;

  bit quiet_phase = 1'b0;
  bit in_moved = 1'b0;
  int hold_epoch = 0;
  int hold_seen = 0;
  int hold_left = 0;

  trimming_two_band_packet_queue #(.BAND_DEPTH(QDEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Free-running clock, 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Apply one descriptor event to the shadow bands and return the outcome it yields.
  function automatic tbpq_pkg::out_item_t band_queue_op(tbpq_pkg::in_item_t ev);
    tbpq_pkg::out_item_t r;
    tbpq_pkg::entry_t e;
    int unsigned lim;
    bit to_data;
    r = '0;
    e = '0;
    to_data = 1'b0;
    r.enq_status = tbpq_pkg::ST_NOT_ENQ;
    lim = (band_limit > QDEPTH) ? QDEPTH : band_limit;
    case (ev.operation)
      tbpq_pkg::OP_ENQ: begin
        e.tag = ev.packet_tag;
        e.is_data = ev.is_data;
        if (ev.is_data && data_cnt + 1 >= lim) begin
          // Data band nearly full: cut the payload and divert to the control band.
          e.chop = 1'b1;
          e.payload = (ev.body_bytes > ev.payload_size) ?
                      ev.body_bytes - ev.payload_size : 16'd0;
          r.enq_status = tbpq_pkg::ST_TRIM;
        end else begin
          e.flags = ev.other_flags;
          e.payload = ev.payload_size;
          to_data = ev.is_data;
          r.enq_status = ev.is_data ? tbpq_pkg::ST_DATA : tbpq_pkg::ST_CTRL;
        end
        if (to_data) begin
          if (data_cnt >= lim) begin
            r.enq_status = tbpq_pkg::ST_DROP;
          end else begin
            data_band[(data_head + data_cnt) % QDEPTH] = e;
            data_cnt++;
          end
        end else begin
          if (ctrl_cnt >= lim) begin
            r.enq_status = tbpq_pkg::ST_DROP;
          end else begin
            ctrl_band[(ctrl_head + ctrl_cnt) % QDEPTH] = e;
            ctrl_cnt++;
          end
        end
      end
      tbpq_pkg::OP_DEQ, tbpq_pkg::OP_PEEK: begin
        // Control band has strict priority over the data band.
        if (ctrl_cnt > 0) begin
          r.out_valid = 1'b1;
          e = ctrl_band[ctrl_head];
          if (ev.operation == tbpq_pkg::OP_DEQ) begin
            ctrl_head = (ctrl_head + 1) % QDEPTH;
            ctrl_cnt--;
          end
        end else if (data_cnt > 0) begin
          r.out_valid = 1'b1;
          r.out_band = 1'b1;
          e = data_band[data_head];
          if (ev.operation == tbpq_pkg::OP_DEQ) begin
            data_head = (data_head + 1) % QDEPTH;
            data_cnt--;
          end
        end
        if (r.out_valid) begin
          r.out_tag = e.tag;
          r.out_is_data = e.is_data;
          r.out_chopped = e.chop;
          r.out_other_flags = e.flags;
          r.out_payload_size = e.payload;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic string show(tbpq_pkg::out_item_t r);
    return $sformatf("status=%0d valid=%0b band=%0b tag=%h data=%0b chop=%0b flags=%h pay=%h",
                     r.enq_status, r.out_valid, r.out_band, r.out_tag, r.out_is_data,
                     r.out_chopped, r.out_other_flags, r.out_payload_size);
  endfunction

  function automatic void note_fault(string what);
    fault_count++;
    if (fault_count <= SHOWN_FAULTS) $display("ERROR at %0t: %s", $time, what);
  endfunction

  function automatic void post(logic [1:0] op, logic dat, logic [5:0] flg,
                               logic [15:0] pay, logic [15:0] body, logic [15:0] tag);
    tbpq_pkg::in_item_t ev;
    ev.operation = op;
    ev.is_data = dat;
    ev.other_flags = flg;
    ev.payload_size = pay;
    ev.body_bytes = body;
    ev.packet_tag = tag;
    queued_events.push_back(ev);
  endfunction

  // Byte counts lean toward the extremes now and then.
  function automatic logic [15:0] byte_count();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic void post_random(int n);
    int pick;
    logic [1:0] op;
    logic [15:0] pay;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      op = (pick < 45) ? tbpq_pkg::OP_ENQ : (pick < 80) ? tbpq_pkg::OP_DEQ :
           (pick < 95) ? tbpq_pkg::OP_PEEK : OP_IDLE;
      pay = byte_count();
      post(op, 1'($urandom_range(1)), 6'($urandom_range(63)), pay,
           ($urandom_range(3) == 0) ? pay : byte_count(), 16'($urandom_range(65535)));
    end
  endfunction

  // Wait until every queued event has been sent and every outcome has come back.
  task automatic drain_queue();
    while (queued_events.size() != 0 || in_valid || awaited_outcomes.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Change the packet limit while the block is idle.
  task automatic write_limit(input logic [tbpq_pkg::MAX_SIZE_W-1:0] value);
    drain_queue();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    band_limit = value;
    n_limits++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Sender: present the next event once the current one has been transferred.
  always @(negedge clk) begin : feed_events
    if (!in_valid || in_moved) begin
      if (queued_events.size() != 0 && (quiet_phase || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        in_data <= queued_events.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin : back_pressure
    if (hold_epoch != hold_seen) begin
      hold_seen <= hold_epoch;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet_phase && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Predict on every input transfer and check every output transfer.
  always @(posedge clk) begin : watch_ports
    tbpq_pkg::out_item_t want;
    in_moved <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        want = band_queue_op(in_data);
        awaited_outcomes.push_back(want);
        n_events++;
        if (want.enq_status == tbpq_pkg::ST_TRIM) n_trimmed++;
        if (want.enq_status == tbpq_pkg::ST_DROP) n_dropped++;
      end
      if (out_valid && !out_stall) begin
        n_results++;
        if (awaited_outcomes.size() == 0) begin
          note_fault({"result with nothing outstanding: ", show(out_data)});
        end else begin
          want = awaited_outcomes.pop_front();
          if (want.out_valid) n_served++;
          if (want !== out_data)
            note_fault($sformatf("expected %s, got %s", show(want), show(out_data)));
        end
      end
    end
  end

  // Test sequence.
  initial begin : run_phases
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset limit: empty reads, the spare opcode, field extremes, priority order.
    post(tbpq_pkg::OP_PEEK, 1'b0, 6'h00, 16'h0000, 16'h0000, 16'h0000);
    post(tbpq_pkg::OP_DEQ, 1'b1, 6'h3F, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    post(OP_IDLE, 1'b1, 6'h3F, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    post(tbpq_pkg::OP_ENQ, 1'b0, 6'h3F, 16'hFFFF, 16'h0000, 16'hFFFF);
    post(tbpq_pkg::OP_ENQ, 1'b1, 6'h3F, 16'h0000, 16'hFFFF, 16'h0000);
    post(tbpq_pkg::OP_ENQ, 1'b1, 6'h00, 16'hABCD, 16'h1234, 16'h5A5A);
    post(tbpq_pkg::OP_PEEK, 1'b0, 6'h00, 16'h0000, 16'h0000, 16'h0000);
    post(tbpq_pkg::OP_DEQ, 1'b0, 6'h00, 16'h0000, 16'h0000, 16'h0000);
    post(tbpq_pkg::OP_PEEK, 1'b0, 6'h00, 16'h0000, 16'h0000, 16'h0000);
    post(tbpq_pkg::OP_DEQ, 1'b0, 6'h00, 16'h0000, 16'h0000, 16'h0000);
    post(tbpq_pkg::OP_DEQ, 1'b0, 6'h00, 16'h0000, 16'h0000, 16'h0000);
    post(tbpq_pkg::OP_DEQ, 1'b0, 6'h00, 16'h0000, 16'h0000, 16'h0000);
    drain_queue();

    // Limit of two: trimming with and without saturation, drops in the control band.
    write_limit(11'd2);
    post(tbpq_pkg::OP_ENQ, 1'b1, 6'h3F, 16'd5, 16'd9, 16'h0101);
    post(tbpq_pkg::OP_ENQ, 1'b1, 6'h3F, 16'd100, 16'd40, 16'h0202);
    post(tbpq_pkg::OP_ENQ, 1'b1, 6'h15, 16'd40, 16'd100, 16'h0303);
    post(tbpq_pkg::OP_ENQ, 1'b0, 6'h2A, 16'd7, 16'd7, 16'h0404);
    post(tbpq_pkg::OP_ENQ, 1'b1, 6'h3F, 16'd1, 16'd2, 16'h0505);
    repeat (4) post(tbpq_pkg::OP_DEQ, 1'b0, 6'h00, 16'h0000, 16'h0000, 16'h0000);
    drain_queue();

    // Limit of zero: every enqueue is dropped.
    write_limit(11'd0);
    post(tbpq_pkg::OP_ENQ, 1'b1, 6'h3F, 16'd10, 16'd20, 16'h0606);
    post(tbpq_pkg::OP_ENQ, 1'b0, 6'h3F, 16'd10, 16'd20, 16'h0707);
    post(tbpq_pkg::OP_PEEK, 1'b0, 6'h00, 16'h0000, 16'h0000, 16'h0000);
    post(tbpq_pkg::OP_DEQ, 1'b0, 6'h00, 16'h0000, 16'h0000, 16'h0000);
    drain_queue();

    // Random traffic across a range of limits.
    write_limit(tbpq_pkg::MAX_SIZE_RST);
    post_random(60);
    write_limit(11'd2);
    post_random(80);
    write_limit(11'd0);
    post_random(40);
    write_limit(11'd1);
    post_random(70);

    // Long receiver hold-off while the sender keeps offering events.
    write_limit(11'd3);
    post_random(90);
    hold_epoch++;
    drain_queue();

    // Limit above the band depth, without any idling: back-to-back random traffic.
    write_limit(11'd2047);
    quiet_phase = 1'b1;
    post_random(90);
    post(tbpq_pkg::OP_ENQ, 1'b1, 6'h3F, 16'h0010, 16'h0020, 16'hBEEF);
    post(tbpq_pkg::OP_PEEK, 1'b0, 6'h00, 16'h0000, 16'h0000, 16'h0000);
    drain_queue();
    quiet_phase = 1'b0;

    write_limit(11'd6);
    post_random(90);
    write_limit(11'd1024);
    post_random(80);
    drain_queue();
    repeat (5) @(posedge clk);

    if (awaited_outcomes.size() != 0)
      note_fault($sformatf("%0d outcomes never arrived", awaited_outcomes.size()));
    $display("Run covered %0d descriptor events and %0d results under %0d limit writes.",
             n_events, n_results, n_limits);
    $display("Of these, %0d packets were trimmed, %0d dropped and %0d served.",
             n_trimmed, n_dropped, n_served);
    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d failures detected.", fault_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    #4000000;
    $display("Timeout: the run did not finish.");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
